// ===== rtl/core/prime_factor_trial_division_core_macros.svh =====
// ----------------------------------------------------------------------------
// Prime factor core assertion macros
// Shared property wrappers, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef PRIME_FACTOR_TRIAL_DIVISION_CORE_MACROS_SVH
`define PRIME_FACTOR_TRIAL_DIVISION_CORE_MACROS_SVH

// Same-cycle implication.
`define PFD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("prime factor core: same-cycle check failed");

// Next-cycle implication.
`define PFD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("prime factor core: next-cycle check failed");

`endif

// ===== rtl/core/pfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Prime factor core package
// Constants, microcode word layout and the microcode program of the core.
// ----------------------------------------------------------------------------
package pfd_pkg;

  localparam int unsigned ValueBitsDefault = 32;
  localparam int unsigned FirstDivisor     = 2;
  localparam int unsigned UpcBits          = 4;

  typedef logic [UpcBits-1:0] upc_t;

  // Datapath action carried out during a step.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_DIV_GO,
    ACT_EMIT_DIV,
    ACT_INC_DIV,
    ACT_EMIT_LAST
  } act_e;

  // Jump condition tested during a step; jump when true, else fall through.
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_NO_START,
    COND_ZERO,
    COND_NOT_ONE,
    COND_DIV_BUSY,
    COND_STOP,
    COND_INEXACT
  } cond_e;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    upc_t  target;
  } ucode_t;

  localparam upc_t StepIdle    = upc_t'(0);
  localparam upc_t StepZero    = upc_t'(1);
  localparam upc_t StepOne     = upc_t'(2);
  localparam upc_t StepUnit    = upc_t'(3);
  localparam upc_t StepDivGo   = upc_t'(4);
  localparam upc_t StepDivWait = upc_t'(5);
  localparam upc_t StepBound   = upc_t'(6);
  localparam upc_t StepExact   = upc_t'(7);
  localparam upc_t StepEmit    = upc_t'(8);
  localparam upc_t StepNext    = upc_t'(9);
  localparam upc_t StepFinal   = upc_t'(10);

  function automatic ucode_t ucode_rom(upc_t addr);
    ucode_t w;
    unique case (addr)
      StepIdle:    w = '{ACT_LOAD,      COND_NO_START, StepIdle};
      StepZero:    w = '{ACT_NONE,      COND_ZERO,     StepIdle};
      StepOne:     w = '{ACT_NONE,      COND_NOT_ONE,  StepDivGo};
      StepUnit:    w = '{ACT_EMIT_LAST, COND_ALWAYS,   StepIdle};
      StepDivGo:   w = '{ACT_DIV_GO,    COND_ALWAYS,   StepDivWait};
      StepDivWait: w = '{ACT_NONE,      COND_DIV_BUSY, StepDivWait};
      StepBound:   w = '{ACT_NONE,      COND_STOP,     StepFinal};
      StepExact:   w = '{ACT_NONE,      COND_INEXACT,  StepNext};
      StepEmit:    w = '{ACT_EMIT_DIV,  COND_ALWAYS,   StepDivGo};
      StepNext:    w = '{ACT_INC_DIV,   COND_ALWAYS,   StepDivGo};
      StepFinal:   w = '{ACT_EMIT_LAST, COND_ALWAYS,   StepIdle};
      default:     w = '{ACT_NONE,      COND_ALWAYS,   StepIdle};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/pfd_div.sv =====
// ----------------------------------------------------------------------------
// Prime factor core divider
// Restoring divider, one quotient bit per cycle, registered results.
// ----------------------------------------------------------------------------
module pfd_div #(
  parameter int unsigned VALUE_BITS = pfd_pkg::ValueBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  go_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [VALUE_BITS-1:0] divisor_i,
  output logic                  busy_o,
  output logic [VALUE_BITS-1:0] quot_o,
  output logic [VALUE_BITS-1:0] rem_o
);

  localparam int unsigned CntBits = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  logic                  busy_q, busy_d;
  logic [CntBits-1:0]    cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] quot_q, quot_d;
  logic [VALUE_BITS-1:0] part_q, part_d;
  logic [VALUE_BITS-1:0] dsr_q, dsr_d;
  logic [VALUE_BITS:0]   shifted;
  logic [VALUE_BITS:0]   diff;

  assign shifted = {part_q, quot_q[VALUE_BITS-1]};
  assign diff    = shifted - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    part_d = part_q;
    dsr_d  = dsr_q;
    if (go_i) begin
      busy_d = 1'b1;
      cnt_d  = CntBits'(VALUE_BITS - 1);
      quot_d = dividend_i;
      part_d = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      // The partial remainder stays below the divisor, so it fits the value width.
      if (!diff[VALUE_BITS]) begin
        part_d = diff[VALUE_BITS-1:0];
        quot_d = {quot_q[VALUE_BITS-2:0], 1'b1};
      end else begin
        part_d = shifted[VALUE_BITS-1:0];
        quot_d = {quot_q[VALUE_BITS-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - CntBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    part_q <= part_d;
    dsr_q  <= dsr_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign rem_o  = part_q;

endmodule

// ===== rtl/core/prime_factor_trial_division_core.sv =====
// ----------------------------------------------------------------------------
// Prime factor core
// Factors an unsigned number by trial division under a microcoded sequencer.
// ----------------------------------------------------------------------------
//  channel   ports                            handshake
//  --------  -------------------------------  --------------------------------
//  item in   number_i                         start high while busy is low
//  result    factor_o, last_o                 valid_o strobe, one cycle each
//
// Each trial divisor runs through the bit-serial divider that the sequencer
// shares for every trial. A number takes about sqrt(number) trials plus one
// per factor. Reset leaves the sequencer at its idle step with no result
// pending. Results cannot be stalled; each is shown for one cycle.
// ----------------------------------------------------------------------------
module prime_factor_trial_division_core #(
  parameter int unsigned VALUE_BITS = pfd_pkg::ValueBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] number_i,
  output logic                  valid_o,
  output logic [VALUE_BITS-1:0] factor_o,
  output logic                  last_o
);

  pfd_pkg::upc_t         upc_q, upc_d;
  pfd_pkg::ucode_t       uword;
  logic [VALUE_BITS-1:0] rem_q, rem_d;
  logic [VALUE_BITS-1:0] div_q, div_d;
  logic                  valid_q, valid_d;
  logic [VALUE_BITS-1:0] factor_q, factor_d;
  logic                  last_q, last_d;
  logic                  cond_hit;
  logic                  div_go;
  logic                  div_busy;
  logic [VALUE_BITS-1:0] quot;
  logic [VALUE_BITS-1:0] rmd;

  assign uword = pfd_pkg::ucode_rom(upc_q);

  always_comb begin
    unique case (uword.cond)
      pfd_pkg::COND_ALWAYS:   cond_hit = 1'b1;
      pfd_pkg::COND_NO_START: cond_hit = !start;
      pfd_pkg::COND_ZERO:     cond_hit = (rem_q == '0);
      pfd_pkg::COND_NOT_ONE:  cond_hit = (rem_q != VALUE_BITS'(1));
      pfd_pkg::COND_DIV_BUSY: cond_hit = div_busy;
      // Trials end once the divisor exceeds remaining / divisor.
      pfd_pkg::COND_STOP:     cond_hit = (div_q > quot);
      pfd_pkg::COND_INEXACT:  cond_hit = (rmd != '0);
      default:                cond_hit = 1'b1;
    endcase
    upc_d = cond_hit ? uword.target : upc_q + pfd_pkg::upc_t'(1);
  end

  always_comb begin
    rem_d    = rem_q;
    div_d    = div_q;
    valid_d  = 1'b0;
    factor_d = factor_q;
    last_d   = last_q;
    div_go   = 1'b0;
    unique case (uword.act)
      pfd_pkg::ACT_NONE: begin
      end
      pfd_pkg::ACT_LOAD: begin
        // Loaded on every idle cycle; the value held at acceptance is the one used.
        rem_d = number_i;
        div_d = VALUE_BITS'(pfd_pkg::FirstDivisor);
      end
      pfd_pkg::ACT_DIV_GO: begin
        div_go = 1'b1;
      end
      pfd_pkg::ACT_EMIT_DIV: begin
        valid_d  = 1'b1;
        factor_d = div_q;
        last_d   = 1'b0;
        rem_d    = quot;
      end
      pfd_pkg::ACT_INC_DIV: begin
        div_d = div_q + VALUE_BITS'(1);
      end
      pfd_pkg::ACT_EMIT_LAST: begin
        valid_d  = 1'b1;
        factor_d = rem_q;
        last_d   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  pfd_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (div_go),
    .dividend_i(rem_q),
    .divisor_i (div_q),
    .busy_o    (div_busy),
    .quot_o    (quot),
    .rem_o     (rmd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q   <= pfd_pkg::StepIdle;
      valid_q <= 1'b0;
    end else begin
      upc_q   <= upc_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    div_q    <= div_d;
    factor_q <= factor_d;
    last_q   <= last_d;
  end

  assign busy     = (upc_q != pfd_pkg::StepIdle);
  assign valid_o  = valid_q;
  assign factor_o = factor_q;
  assign last_o   = last_q;

endmodule

// ===== rtl/core/pfd_checker.sv =====
// ----------------------------------------------------------------------------
// Prime factor core checker
// Port-level checks on item acceptance and result sequencing.
// ----------------------------------------------------------------------------
`include "prime_factor_trial_division_core_macros.svh"

module pfd_checker #(
  parameter int unsigned VALUE_BITS = pfd_pkg::ValueBitsDefault
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start,
  input logic                  busy,
  input logic                  valid_o,
  input logic [VALUE_BITS-1:0] factor_o,
  input logic                  last_o
);

  // An accepted item always makes the core busy in the next cycle.
  `PFD_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  // A result that is not the final one means the item is still at work.
  `PFD_ASSERT_IMP(a_more_busy, valid_o && !last_o, busy)
  // The final result appears once the core is idle again.
  `PFD_ASSERT_IMP(a_last_idle, valid_o && last_o, !busy)
  // Factors are never zero, and results never come in adjacent cycles.
  `PFD_ASSERT_IMP(a_factor_nz, valid_o, factor_o != '0)
  `PFD_ASSERT_NXT(a_gap, valid_o && !last_o, !valid_o)

endmodule

bind prime_factor_trial_division_core pfd_checker #(
  .VALUE_BITS(VALUE_BITS)
) u_pfd_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .valid_o (valid_o),
  .factor_o(factor_o),
  .last_o  (last_o)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prime factor core testbench
// Feeds numbers to the trial-division core, predicts the ascending factor
// list of each one and checks every strobed factor and its last mark in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned VALUE_BITS = pfd_pkg::ValueBitsDefault;
  localparam int unsigned MaxFactors = VALUE_BITS - 1;
  localparam int unsigned CycleLimit = 20_000_000;
  localparam int unsigned MaxPrinted = 40;

  typedef logic [VALUE_BITS-1:0] value_t;

  typedef struct packed {
    value_t factor;
    logic   last;
  } factor_t;

  logic   clk_i;
  logic   rst_ni;
  logic   start;
  logic   busy;
  value_t number_i;
  logic   valid_o;
  value_t factor_o;
  logic   last_o;

  factor_t     pending_factors[$];
  int unsigned error_count;
  int unsigned cycle_count;
  bit          idling_on;

  prime_factor_trial_division_core #(
    .VALUE_BITS(VALUE_BITS)
  ) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .number_i(number_i),
    .valid_o (valid_o),
    .factor_o(factor_o),
    .last_o  (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(input string msg);
    if (error_count < MaxPrinted) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // Trial division up to the square root of what remains; a remainder above
  // one is the largest prime factor.
  function automatic void predict_factors(input value_t value);
    logic [63:0] rest;
    logic [63:0] trial;
    value_t      found[$];
    factor_t     entry;
    int unsigned i;
    rest  = 64'(value);
    trial = 64'(pfd_pkg::FirstDivisor);
    if (rest == 0) begin
      return;
    end
    if (rest == 1) begin
      found.push_back(value_t'(1));
    end else begin
      while (trial * trial <= rest) begin
        if (rest % trial == 0) begin
          if (found.size() < MaxFactors) begin
            found.push_back(value_t'(trial));
          end
          rest = rest / trial;
        end else begin
          trial++;
        end
      end
      if (rest > 1 && found.size() < MaxFactors) begin
        found.push_back(value_t'(rest));
      end
    end
    for (i = 0; i < found.size(); i++) begin
      entry.factor = found[i];
      entry.last   = (i == found.size() - 1);
      pending_factors.push_back(entry);
    end
  endfunction

  // Product of random small factors, so the trial divisor never climbs far.
  function automatic value_t smooth_number(input int unsigned factor_count,
                                           input int unsigned max_factor);
    logic [63:0] product;
    logic [63:0] f;
    int unsigned i;
    product = 64'd1;
    for (i = 0; i < factor_count; i++) begin
      f = 64'($urandom_range(max_factor, 2));
      if (product * f > 64'hFFFF_FFFF) begin
        break;
      end
      product = product * f;
    end
    return value_t'(product);
  endfunction

  // Holds start high until the item is taken; start stays high afterwards
  // unless an idle burst follows, so back-to-back items need no toggling.
  task automatic send_number(input value_t value);
    start    <= 1'b1;
    number_i <= value;
    do @(posedge clk_i); while (busy);
    predict_factors(value);
    if (idling_on && $urandom_range(3, 0) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    factor_t entry;
    if (rst_ni && valid_o) begin
      if (pending_factors.size() == 0) begin
        flag_mismatch($sformatf("unexpected factor %0d last %0b", factor_o, last_o));
      end else begin
        entry = pending_factors.pop_front();
        if (factor_o !== entry.factor) begin
          flag_mismatch($sformatf("factor %0d, expected %0d", factor_o, entry.factor));
        end
        if (last_o !== entry.last) begin
          flag_mismatch($sformatf("last %0b on factor %0d, expected %0b",
                                  last_o, factor_o, entry.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("ERROR: timeout with %0d factors outstanding", pending_factors.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  // Zero, one, repeats of both, primes of several sizes and two prime squares.
  task automatic test_degenerate_inputs();
    send_number(value_t'(0));
    send_number(value_t'(0));
    send_number(value_t'(1));
    send_number(value_t'(1));
    send_number(value_t'(0));
    send_number(value_t'(2));
    send_number(value_t'(3));
    send_number(value_t'(4));
    send_number(value_t'(4093));
    send_number(value_t'(65521));
    send_number(value_t'(63001));
    send_number(value_t'(1048573));
  endtask

  // Field extremes and alternating bit patterns, all with cheap factorings.
  task automatic test_bit_patterns();
    send_number('1);
    send_number(value_t'(32'h5555_5555));
    send_number(value_t'(32'hAAAA_AAAA));
    send_number(value_t'(32'h0000_FFFF));
    send_number(value_t'(32'd4294955008));
  endtask

  // Long factor chains, up to the longest a 32-bit number can have.
  task automatic test_long_factor_chains();
    send_number(value_t'(32'h8000_0000));
    send_number(value_t'(32'hC000_0000));
    send_number(value_t'(32'd3486784401));
    send_number(value_t'(30030));
    send_number(value_t'(6));
  endtask

  // Mostly smooth numbers across the whole range; a few wider ones with a
  // larger prime factor, and a few tiny raw values that hit zero and one.
  task automatic test_random_numbers(input int unsigned item_count);
    int unsigned i;
    int unsigned pick;
    for (i = 0; i < item_count; i++) begin
      pick = $urandom_range(19, 0);
      if (pick == 0) begin
        send_number(value_t'($urandom_range(32'h000F_FFFF, 2)) << $urandom_range(12, 0));
      end else if (pick < 3) begin
        send_number(value_t'($urandom_range(255, 0)));
      end else begin
        send_number(smooth_number($urandom_range(MaxFactors, 1), $urandom_range(40, 2)));
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    number_i    = '0;
    idling_on   = 1'b1;
    error_count = 0;
    cycle_count = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_degenerate_inputs();
    test_bit_patterns();
    test_long_factor_chains();
    test_random_numbers(80);
    // Closing stretch: the sender never pauses.
    idling_on = 1'b0;
    test_random_numbers(20);

    start <= 1'b0;
    do @(posedge clk_i); while (pending_factors.size() != 0 || busy);
    repeat (50) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
